/* sv/hse_pkg.sv */
// Shared types and constants for the heap sort engine.
package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CH_W      = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_BUILD_INIT,
    ST_BUILD_RD,
    ST_SIFT_FIRST,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SIFT_DONE,
    ST_SORT_RD,
    ST_SORT_SWAP,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_BUILD_RD,
    OP_SIFT_FIRST,
    OP_SIFT_RD,
    OP_SIFT_STEP,
    OP_K_DEC,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_SWAP,
    OP_OUT_INIT,
    OP_OUT_RD,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic   collect;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic len_lt2;
    logic k_is_one;
    logic k_is_last;
    logic sift_more;
    logic out_free;
  } status_t;

endpackage

/* sv/hse_ctrl.sv */
// Sequencer for the heap sort engine: collect, build, sort and drain phases.
module hse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  hse_pkg::status_t status,
  output hse_pkg::cmd_t    cmd
);

  hse_pkg::state_t state, state_next;
  logic            sort_phase, sort_phase_next;

  // Hold state and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hse_pkg::ST_COLLECT;
      sort_phase <= 1'b0;
    end else begin
      state      <= state_next;
      sort_phase <= sort_phase_next;
    end
  end

  // Next state
  always_comb begin
    state_next      = state;
    sort_phase_next = sort_phase;
    unique case (state)
      hse_pkg::ST_COLLECT: begin
        if (status.last_in) state_next = hse_pkg::ST_BUILD_INIT;
      end
      hse_pkg::ST_BUILD_INIT: begin
        sort_phase_next = 1'b0;
        state_next = status.len_lt2 ? hse_pkg::ST_OUT_RD : hse_pkg::ST_BUILD_RD;
      end
      hse_pkg::ST_BUILD_RD:  state_next = hse_pkg::ST_SIFT_FIRST;
      hse_pkg::ST_SIFT_FIRST: state_next = hse_pkg::ST_SIFT_CMP;
      hse_pkg::ST_SIFT_RD:   state_next = hse_pkg::ST_SIFT_CMP;
      hse_pkg::ST_SIFT_CMP: begin
        state_next = status.sift_more ? hse_pkg::ST_SIFT_RD : hse_pkg::ST_SIFT_DONE;
      end
      hse_pkg::ST_SIFT_DONE: begin
        if (!sort_phase) begin
          if (status.k_is_one) begin
            sort_phase_next = 1'b1;
            state_next      = hse_pkg::ST_SORT_RD;
          end else begin
            state_next = hse_pkg::ST_BUILD_RD;
          end
        end else begin
          state_next = status.k_is_one ? hse_pkg::ST_OUT_RD : hse_pkg::ST_SORT_RD;
        end
      end
      hse_pkg::ST_SORT_RD:   state_next = hse_pkg::ST_SORT_SWAP;
      hse_pkg::ST_SORT_SWAP: state_next = hse_pkg::ST_SIFT_RD;
      hse_pkg::ST_OUT_RD:    state_next = hse_pkg::ST_OUT_LOAD;
      hse_pkg::ST_OUT_LOAD: begin
        if (status.out_free) begin
          state_next = status.k_is_last ? hse_pkg::ST_COLLECT : hse_pkg::ST_OUT_RD;
        end
      end
      default: state_next = hse_pkg::ST_COLLECT;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd.collect = 1'b0;
    cmd.op      = hse_pkg::OP_NONE;
    unique case (state)
      hse_pkg::ST_COLLECT:    cmd.collect = 1'b1;
      hse_pkg::ST_BUILD_INIT: begin
        cmd.op = status.len_lt2 ? hse_pkg::OP_OUT_INIT : hse_pkg::OP_START;
      end
      hse_pkg::ST_BUILD_RD:   cmd.op = hse_pkg::OP_BUILD_RD;
      hse_pkg::ST_SIFT_FIRST: cmd.op = hse_pkg::OP_SIFT_FIRST;
      hse_pkg::ST_SIFT_RD:    cmd.op = hse_pkg::OP_SIFT_RD;
      hse_pkg::ST_SIFT_CMP:   cmd.op = hse_pkg::OP_SIFT_STEP;
      hse_pkg::ST_SIFT_DONE: begin
        if (!status.k_is_one)  cmd.op = hse_pkg::OP_K_DEC;
        else if (!sort_phase)  cmd.op = hse_pkg::OP_SORT_INIT;
        else                   cmd.op = hse_pkg::OP_OUT_INIT;
      end
      hse_pkg::ST_SORT_RD:    cmd.op = hse_pkg::OP_SORT_RD;
      hse_pkg::ST_SORT_SWAP:  cmd.op = hse_pkg::OP_SORT_SWAP;
      hse_pkg::ST_OUT_RD:     cmd.op = hse_pkg::OP_OUT_RD;
      hse_pkg::ST_OUT_LOAD: begin
        if (status.out_free) cmd.op = hse_pkg::OP_OUT_LOAD;
      end
      default: cmd.op = hse_pkg::OP_NONE;
    endcase
  end

endmodule

/* sv/hse_dpath.sv */
// Datapath of the heap sort engine: element memory, counters, compare and output stage.
module hse_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  hse_pkg::cmd_t                      cmd,
  output hse_pkg::status_t                   status,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [hse_pkg::DATA_W-1:0]  s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic signed [hse_pkg::DATA_W-1:0]  m_tdata,
  output logic                               m_tlast,
  output logic                               m_tuser
);

  localparam int IW = hse_pkg::IDX_W;
  localparam int CW = hse_pkg::CNT_W;
  localparam int HW = hse_pkg::CH_W;
  localparam int DW = hse_pkg::DATA_W;

  logic signed [DW-1:0] mem [hse_pkg::MAX_ITEMS];
  logic signed [DW-1:0] rd0, rd1, cur;
  logic [CW-1:0]        count;
  logic                 overflow;
  logic [IW-1:0]        k, pos;
  logic [CW-1:0]        sift_len;

  logic                 accept, store_full;
  logic [HW-1:0]        left, right;
  logic                 left_wins, right_wins;
  logic signed [DW-1:0] top_val;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr0, rd_addr1;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic signed [DW-1:0] wr_data;
  logic                 out_free, out_final;

  assign s_tready   = cmd.collect && !rst;
  assign accept     = s_tvalid && s_tready;
  assign store_full = (count == CW'(hse_pkg::MAX_ITEMS));
  assign out_free   = !m_tvalid || m_tready;
  assign out_final  = ((CW'(k) + CW'(1)) == count);

  // Pick the larger child against the value being sifted
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + HW'(1);
  assign left_wins  = (left < HW'(sift_len)) && (rd0 > cur);
  assign top_val    = left_wins ? rd0 : cur;
  assign right_wins = (right < HW'(sift_len)) && (rd1 > top_val);

  assign status.last_in   = accept && s_tlast;
  assign status.len_lt2   = (count < CW'(2));
  assign status.k_is_one  = (k == IW'(1));
  assign status.k_is_last = out_final;
  assign status.sift_more = left_wins || right_wins;
  assign status.out_free  = out_free;

  // Select read addresses
  always_comb begin
    rd_en    = 1'b0;
    rd_addr0 = k;
    rd_addr1 = k;
    unique case (cmd.op)
      hse_pkg::OP_BUILD_RD: begin
        rd_en    = 1'b1;
        rd_addr0 = k - IW'(1);
      end
      hse_pkg::OP_SIFT_FIRST, hse_pkg::OP_SIFT_RD: begin
        rd_en    = 1'b1;
        rd_addr0 = left[IW-1:0];
        rd_addr1 = right[IW-1:0];
      end
      hse_pkg::OP_SORT_RD: begin
        rd_en    = 1'b1;
        rd_addr0 = '0;
        rd_addr1 = k;
      end
      hse_pkg::OP_OUT_RD: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  // Select the write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    priority if (accept && !store_full) begin
      wr_en   = 1'b1;
      wr_addr = count[IW-1:0];
      wr_data = s_tdata;
    end else if (cmd.op == hse_pkg::OP_SIFT_STEP) begin
      wr_en   = 1'b1;
      wr_data = right_wins ? rd1 : (left_wins ? rd0 : cur);
    end else if (cmd.op == hse_pkg::OP_SORT_SWAP) begin
      wr_en   = 1'b1;
      wr_addr = k;
      wr_data = rd0;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Element memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd0 <= mem[rd_addr0];
      rd1 <= mem[rd_addr1];
    end
  end

  // Advance counters and the sift position
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hse_pkg::OP_START:     k <= count[IW:1];
      hse_pkg::OP_BUILD_RD: begin
        pos      <= k - IW'(1);
        sift_len <= count;
      end
      hse_pkg::OP_SIFT_FIRST: cur <= rd0;
      hse_pkg::OP_SIFT_STEP: begin
        if (right_wins)     pos <= right[IW-1:0];
        else if (left_wins) pos <= left[IW-1:0];
      end
      hse_pkg::OP_K_DEC:     k <= k - IW'(1);
      hse_pkg::OP_SORT_INIT: k <= IW'(count - CW'(1));
      hse_pkg::OP_SORT_SWAP: begin
        cur      <= rd1;
        pos      <= '0;
        sift_len <= CW'(k);
      end
      hse_pkg::OP_OUT_INIT:  k <= '0;
      hse_pkg::OP_OUT_LOAD:  k <= k + IW'(1);
      default: ;
    endcase
  end

  // Track fill count and overflow of the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.op == hse_pkg::OP_OUT_LOAD && out_final) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (store_full) overflow <= 1'b1;
      else            count    <= count + CW'(1);
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == hse_pkg::OP_OUT_LOAD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == hse_pkg::OP_OUT_LOAD) begin
      m_tdata <= rd0;
      m_tlast <= out_final;
      m_tuser <= out_final && overflow;
    end
  end

endmodule

/* sv/heap_sort_engine.sv */
// Top level of the heap sort engine: controller plus datapath.
//
// Usage: send a data set on the slave stream, one signed 32-bit value per
// item on s_tdata, with s_tlast high on the final item. Up to 64 values are
// stored; further values of the set are discarded. After the last item the
// block builds a max-heap in its element memory, sorts it in place and then
// emits every stored value in ascending order on the master stream. m_tlast
// marks the largest (final) result, and m_tuser on that result is high if
// values of the set were discarded.
// Timing: s_tready is high only while a set is being collected, one item
// per cycle. Each sift-down level reads both children, then compares and
// writes back, on the single-write, dual-read memory. On top of that the
// heap build reads each parent node before its sift and the sort swaps the
// root with the last heap value before each sift; the drain then reads
// each result from the memory and loads it into the output register.
// A stalled receiver holds the output register and pauses the drain; the
// next set is accepted while the final result still waits to be taken.
// Reset (rst, synchronous) empties the set and drops any pending result.
module heap_sort_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [hse_pkg::DATA_W-1:0]  s_tdata,   // value
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic signed [hse_pkg::DATA_W-1:0]  m_tdata,   // sorted_value
  output logic                               m_tlast,
  output logic                               m_tuser    // dropped
);

  hse_pkg::cmd_t    cmd;
  hse_pkg::status_t status;

  hse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  hse_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
